>>> design/atbs_pkg.sv
// shared types, constants and lookup functions for the modem bring-up sequencer
// no dependencies; imported by atbs_line_ram and at_command_bringup_sequencer_core
package atbs_pkg;

    localparam int LINE_DEPTH = 128;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int EUI_CHARS  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int EUI_CAP    = (EUI_CHARS > MAX_RESULTS) ? MAX_RESULTS : EUI_CHARS;
    localparam int EUI_CW     = $clog2(EUI_CAP + 1);
    localparam int CFG_IDX_W  = 4;
    localparam int PAT_MAX    = 11;

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic [3:0]  RETRIES_RESET = 4'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRIES = 4'd1;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_BYTE   = 2'd1;
    localparam logic [1:0] REQ_BUTTON = 2'd2;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_EUI    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_NO_RESP   = 2'd0;
    localparam logic [1:0] ST_STOPPED   = 2'd1;
    localparam logic [1:0] ST_BAD_FMT   = 2'd2;
    localparam logic [1:0] ST_EMPTY_EUI = 2'd3;

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_WAIT_AT  = 2'd1;
    localparam logic [1:0] PH_WAIT_VER = 2'd2;
    localparam logic [1:0] PH_WAIT_ID  = 2'd3;

    localparam logic [1:0] CMD_AT  = 2'd0;
    localparam logic [1:0] CMD_VER = 2'd1;
    localparam logic [1:0] CMD_ID  = 2'd2;

    localparam logic [1:0] PAT_OK  = 2'd0;
    localparam logic [1:0] PAT_VER = 2'd1;
    localparam logic [1:0] PAT_ID  = 2'd2;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [7:0] TXT_AT  [4]  = '{8'h41, 8'h54, 8'h0D, 8'h0A};
    localparam logic [7:0] TXT_VER [8]  = '{8'h41, 8'h54, 8'h2B, 8'h56, 8'h45, 8'h52,
                                            8'h0D, 8'h0A};
    localparam logic [7:0] TXT_ID  [14] = '{8'h41, 8'h54, 8'h2B, 8'h49, 8'h44, 8'h3D,
                                            8'h44, 8'h65, 8'h76, 8'h45, 8'h75, 8'h69,
                                            8'h0D, 8'h0A};
    localparam logic [7:0] TXT_OK  [2]  = '{8'h4F, 8'h4B};
    localparam logic [7:0] TXT_PVER [4] = '{8'h2B, 8'h56, 8'h45, 8'h52};
    localparam logic [7:0] TXT_PID [11] = '{8'h2B, 8'h49, 8'h44, 8'h3A, 8'h20, 8'h44,
                                            8'h65, 8'h76, 8'h45, 8'h75, 8'h69};

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [1:0] status_code;
        logic       last;
    } out_item_t;

    function automatic logic [3:0] cmd_len(input logic [1:0] sel);
        logic [3:0] n;
        case (sel)
            CMD_AT:  n = 4'd4;
            CMD_VER: n = 4'd8;
            default: n = 4'd14;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] cmd_byte(input logic [1:0] sel, input logic [3:0] idx);
        logic [7:0] b;
        case (sel)
            CMD_AT:  b = TXT_AT[idx[1:0]];
            CMD_VER: b = TXT_VER[idx[2:0]];
            default: b = (idx < 4'd14) ? TXT_ID[idx] : CH_NUL;
        endcase
        return b;
    endfunction

    function automatic int pat_len(input logic [1:0] sel);
        int n;
        case (sel)
            PAT_OK:  n = 2;
            PAT_VER: n = 4;
            default: n = 11;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] pat_byte(input logic [1:0] sel, input int k);
        logic [7:0] b;
        case (sel)
            PAT_OK:  b = TXT_OK[k % 2];
            PAT_VER: b = TXT_PVER[k % 4];
            default: b = TXT_PID[k % 11];
        endcase
        return b;
    endfunction

    // window[0] is the newest byte; pattern ends at the newest byte
    function automatic logic pat_match(input logic [1:0] sel,
                                       input logic [PAT_MAX-1:0][7:0] window,
                                       input logic [LINE_AW:0] pos);
        logic ok;
        int   plen;
        ok   = 1'b1;
        plen = pat_len(sel);
        if (int'(pos) + 1 < plen)
            ok = 1'b0;
        for (int k = 0; k < PAT_MAX; k++) begin
            if (k < plen && window[plen - 1 - k] != pat_byte(sel, k))
                ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
            r = c + 8'd32;
        return r;
    endfunction

endpackage

>>> design/atbs_line_ram.sv
// line buffer: one write port, one read port with registered read data
// depends on atbs_pkg for depth and address width
module atbs_line_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [atbs_pkg::LINE_AW-1:0] waddr,
    input  logic [7:0]                  wdata,
    input  logic                        re,
    input  logic [atbs_pkg::LINE_AW-1:0] raddr,
    output logic [7:0]                  rdata
);
    import atbs_pkg::*;

    logic [7:0] mem [LINE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/at_command_bringup_sequencer_core.sv
// modem bring-up sequencer over a uart: command sender, line scanner, deveui extractor
// depends on atbs_pkg and atbs_line_ram
//
// usage:
//   in channel (in_valid/in_stall, in_data): ticks, received bytes and button presses.
//   out channel (out_valid/out_stall, out_data): transmit bytes, deveui characters and
//   status events; last marks the final result caused by one input item.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): 0 timeout_ticks, 1 max_retries;
//   cfg_ready is always high, write only while the block is idle.
// flow:
//   a tick, a stored byte or an ignored item is handled in the accepting cycle. a command
//   sends its bytes one by one, then flushes its last result. a line end checks the last
//   stored byte, if any, for a cr, then walks the line buffer through its single read port,
//   a read state and a check state per stored byte, then sends any command; a deveui line
//   is walked once more for extraction. in_stall is high while busy.
//   results sit in a hold register and an output register; when the receiver stalls the
//   sequencer waits and nothing is lost.
// reset:
//   phase idle, counters zero, registers at 500 ticks and 5 retries; the line buffer is
//   not cleared, only bytes written since the line began are ever read.
module at_command_bringup_sequencer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  atbs_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output atbs_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [atbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                     cfg_data
);
    import atbs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CMD   = 4'd1;
    localparam logic [3:0] S_CR    = 4'd2;
    localparam logic [3:0] S_M_RD  = 4'd3;
    localparam logic [3:0] S_M_CHK = 4'd4;
    localparam logic [3:0] S_X_RD  = 4'd5;
    localparam logic [3:0] S_X_CHK = 4'd6;
    localparam logic [3:0] S_X_END = 4'd7;
    localparam logic [3:0] S_FLUSH = 4'd8;

    localparam logic [LINE_AW-1:0] LEN_MAX = LINE_AW'(LINE_DEPTH - 1);

    logic [3:0]          state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    logic [3:0]          retry_reg, retry_next;
    logic [15:0]         timer_reg, timer_next;
    logic [LINE_AW-1:0]  len_reg, len_next;
    logic [15:0]         timeout_reg;
    logic [3:0]          maxr_reg;
    logic [1:0]          cmd_sel_reg, cmd_sel_next;
    logic [3:0]          cmd_idx_reg, cmd_idx_next;
    logic [LINE_AW:0]    idx_reg, idx_next;
    logic [LINE_AW-1:0]  eff_reg, eff_next;
    logic [PAT_MAX-1:0][7:0] win_reg, win_next;
    logic                found_reg, found_next;
    logic                skip_reg, skip_next;
    logic [EUI_CW-1:0]   n_reg, n_next;
    out_item_t           hold_reg, hold_next;
    logic                hold_valid_reg, hold_valid_next;
    out_item_t           out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                emit_req;
    out_item_t           emit_item;
    logic                emit_ok;
    logic                flush_req;
    logic                out_free;
    logic                rd_en;
    logic [LINE_AW-1:0]  rd_addr;
    logic [7:0]          rd_data;
    logic                wr_en;
    logic [15:0]         tick_next;
    logic [PAT_MAX-1:0][7:0] win_shift;

    atbs_line_ram u_line_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (len_reg),
        .wdata (in_data.rx_byte),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_ok   = !hold_valid_reg || out_free;
    assign tick_next = (timer_reg == 16'hFFFF) ? timer_reg : timer_reg + 16'd1;
    assign win_shift = {win_reg[PAT_MAX-2:0], rd_data};

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        retry_next   = retry_reg;
        timer_next   = timer_reg;
        len_next     = len_reg;
        cmd_sel_next = cmd_sel_reg;
        cmd_idx_next = cmd_idx_reg;
        idx_next     = idx_reg;
        eff_next     = eff_reg;
        win_next     = win_reg;
        found_next   = found_reg;
        skip_next    = skip_reg;
        n_next       = n_reg;
        emit_req     = 1'b0;
        emit_item    = '0;
        flush_req    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = idx_reg[LINE_AW-1:0];
        wr_en        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.req_type)
                        REQ_BUTTON:
                        begin
                            if (phase_reg == PH_IDLE)
                            begin
                                retry_next = 4'd0;
                                if (maxr_reg == 4'd0)
                                begin
                                    emit_req   = 1'b1;
                                    emit_item  = '{KIND_STATUS, 8'd0, ST_NO_RESP, 1'b0};
                                    state_next = S_FLUSH;
                                end
                                else
                                begin
                                    cmd_sel_next = CMD_AT;
                                    cmd_idx_next = 4'd0;
                                    retry_next   = 4'd1;
                                    phase_next   = PH_WAIT_AT;
                                    timer_next   = 16'd0;
                                    len_next     = '0;
                                    state_next   = S_CMD;
                                end
                            end
                        end
                        REQ_TICK:
                        begin
                            if (phase_reg != PH_IDLE)
                            begin
                                timer_next = tick_next;
                                if (tick_next >= timeout_reg)
                                begin
                                    timer_next = 16'd0;
                                    len_next   = '0;
                                    if (phase_reg == PH_WAIT_AT && retry_reg < maxr_reg)
                                    begin
                                        cmd_sel_next = CMD_AT;
                                        cmd_idx_next = 4'd0;
                                        retry_next   = retry_reg + 4'd1;
                                        state_next   = S_CMD;
                                    end
                                    else
                                    begin
                                        emit_req   = 1'b1;
                                        emit_item  = '{KIND_STATUS, 8'd0,
                                                      (phase_reg == PH_WAIT_AT) ?
                                                      ST_NO_RESP : ST_STOPPED, 1'b0};
                                        phase_next = PH_IDLE;
                                        state_next = S_FLUSH;
                                    end
                                end
                            end
                        end
                        REQ_BYTE:
                        begin
                            if (phase_reg != PH_IDLE)
                            begin
                                if (in_data.rx_byte == CH_LF)
                                begin
                                    idx_next = '0;
                                    win_next = '0;
                                    if (len_reg == '0)
                                    begin
                                        eff_next   = '0;
                                        state_next = S_M_RD;
                                    end
                                    else
                                    begin
                                        // look at the last stored byte for a trailing cr
                                        rd_en      = 1'b1;
                                        rd_addr    = len_reg - 1'b1;
                                        state_next = S_CR;
                                    end
                                end
                                else if (len_reg < LEN_MAX)
                                begin
                                    wr_en    = 1'b1;
                                    len_next = len_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CMD:
            begin
                emit_req  = 1'b1;
                emit_item = '{KIND_TX, cmd_byte(cmd_sel_reg, cmd_idx_reg), ST_NO_RESP, 1'b0};
                if (emit_ok)
                begin
                    cmd_idx_next = cmd_idx_reg + 4'd1;
                    if (cmd_idx_reg == cmd_len(cmd_sel_reg) - 4'd1)
                        state_next = S_FLUSH;
                end
            end
            S_CR:
            begin
                eff_next   = (rd_data == CH_CR) ? len_reg - 1'b1 : len_reg;
                state_next = S_M_RD;
            end
            S_M_RD:
            begin
                if (idx_reg < {1'b0, eff_reg})
                begin
                    rd_en      = 1'b1;
                    state_next = S_M_CHK;
                end
                else
                begin
                    // no match: fresh wait
                    timer_next = 16'd0;
                    len_next   = '0;
                    state_next = S_FLUSH;
                end
            end
            S_M_CHK:
            begin
                if (rd_data == CH_NUL)
                begin
                    timer_next = 16'd0;
                    len_next   = '0;
                    state_next = S_FLUSH;
                end
                else
                begin
                    win_next = win_shift;
                    if (pat_match(phase_reg - 2'd1, win_shift, idx_reg))
                    begin
                        timer_next   = 16'd0;
                        len_next     = '0;
                        cmd_idx_next = 4'd0;
                        case (phase_reg)
                            PH_WAIT_AT:
                            begin
                                cmd_sel_next = CMD_VER;
                                phase_next   = PH_WAIT_VER;
                                state_next   = S_CMD;
                            end
                            PH_WAIT_VER:
                            begin
                                cmd_sel_next = CMD_ID;
                                phase_next   = PH_WAIT_ID;
                                state_next   = S_CMD;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                                idx_next   = '0;
                                found_next = 1'b0;
                                skip_next  = 1'b0;
                                n_next     = '0;
                                state_next = S_X_RD;
                            end
                        endcase
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_M_RD;
                    end
                end
            end
            S_X_RD:
            begin
                if (idx_reg < {1'b0, eff_reg})
                begin
                    rd_en      = 1'b1;
                    state_next = S_X_CHK;
                end
                else
                begin
                    state_next = S_X_END;
                end
            end
            S_X_CHK:
            begin
                if (rd_data == CH_NUL)
                begin
                    state_next = S_X_END;
                end
                else if (!found_reg)
                begin
                    if (rd_data == CH_COMMA)
                    begin
                        found_next = 1'b1;
                        skip_next  = 1'b1;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_X_RD;
                end
                else if (skip_reg || rd_data == CH_COLON)
                begin
                    // the character right after the comma is skipped
                    skip_next  = 1'b0;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_X_RD;
                end
                else
                begin
                    emit_req  = 1'b1;
                    emit_item = '{KIND_EUI, to_lower(rd_data), ST_NO_RESP, 1'b0};
                    if (emit_ok)
                    begin
                        n_next   = n_reg + 1'b1;
                        idx_next = idx_reg + 1'b1;
                        if (n_reg == EUI_CW'(EUI_CAP - 1))
                            state_next = S_FLUSH;
                        else
                            state_next = S_X_RD;
                    end
                end
            end
            S_X_END:
            begin
                if (!found_reg || n_reg == '0)
                begin
                    emit_req  = 1'b1;
                    emit_item = '{KIND_STATUS, 8'd0,
                                  found_reg ? ST_EMPTY_EUI : ST_BAD_FMT, 1'b0};
                    if (emit_ok)
                        state_next = S_FLUSH;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                flush_req = 1'b1;
                if (out_free || !hold_valid_reg)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold register keeps the newest result until it is known whether it ends the item
    always_comb
    begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (emit_req && emit_ok)
        begin
            if (hold_valid_reg)
            begin
                out_next       = hold_reg;
                out_valid_next = 1'b1;
            end
            hold_next       = emit_item;
            hold_valid_next = 1'b1;
        end
        else if (flush_req && hold_valid_reg && out_free)
        begin
            out_next        = hold_reg;
            out_next.last   = 1'b1;
            out_valid_next  = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_IDLE;
            retry_reg      <= 4'd0;
            timer_reg      <= 16'd0;
            len_reg        <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            maxr_reg       <= RETRIES_RESET;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            skip_reg       <= 1'b0;
            n_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            retry_reg      <= retry_next;
            timer_reg      <= timer_next;
            len_reg        <= len_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            found_reg      <= found_next;
            skip_reg       <= skip_next;
            n_reg          <= n_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TIMEOUT)
                    timeout_reg <= cfg_data;
                else if (cfg_index == CFG_RETRIES)
                    maxr_reg <= cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_sel_reg <= cmd_sel_next;
        cmd_idx_reg <= cmd_idx_next;
        idx_reg     <= idx_next;
        eff_reg     <= eff_next;
        win_reg     <= win_next;
        hold_reg    <= hold_next;
        out_reg     <= out_next;
    end

    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_valid_reg)
        else $error("result left in hold register while idle");

    a_eui_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg <= EUI_CW'(EUI_CAP)))
        else $error("deveui character count beyond cap");

    a_line_len: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg <= LEN_MAX))
        else $error("line length beyond buffer");

    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && hold_valid_reg && out_free) |=>
        (out_valid_reg && out_reg.last))
        else $error("flushed result not marked last");

endmodule

>>> tb/sv/atbs_checker.sv
`timescale 1ns / 100ps
// checker for the modem bring-up sequencer: watches the in, out and cfg channels
// depends on atbs_pkg; predicts results per accepted item and compares them in order
module atbs_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  atbs_pkg::in_item_t   in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  atbs_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [3:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output int                   fail_count,
    output int                   pending
);
    import atbs_pkg::*;

    logic [15:0] timeout_reg;
    logic [3:0]  retries_reg;
    logic [1:0]  ph;
    logic [3:0]  tries;
    logic [15:0] timer;
    logic [7:0]  line_buf [LINE_DEPTH];
    int          line_len;
    out_item_t   want_q [$];
    out_item_t   item_res [$];

    function automatic out_item_t mk(logic [1:0] k, logic [7:0] b, logic [1:0] s);
        out_item_t r;
        r.out_kind = k;
        r.out_byte = b;
        r.status_code = s;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic put(logic [1:0] k, logic [7:0] b, logic [1:0] s);
        if (item_res.size() < MAX_RESULTS)
            item_res.push_back(mk(k, b, s));
    endtask

    task automatic send_attempt();
        if (tries >= retries_reg) begin
            put(KIND_STATUS, 8'h00, ST_NO_RESP);
            ph = PH_IDLE;
        end else begin
            foreach (TXT_AT[i]) put(KIND_TX, TXT_AT[i], 2'd0);
            tries = tries + 4'd1;
            ph = PH_WAIT_AT;
            timer = 0;
            line_len = 0;
        end
    endtask

    function automatic bit contains(int len, logic [1:0] sel);
        int plen;
        bit hit;
        plen = (sel == PAT_OK) ? 2 : (sel == PAT_VER) ? 4 : 11;
        for (int i = 0; i + plen <= len; i++) begin
            hit = 1;
            for (int j = 0; j < plen; j++) begin
                if (sel == PAT_OK && line_buf[i+j] != TXT_OK[j]) hit = 0;
                if (sel == PAT_VER && line_buf[i+j] != TXT_PVER[j]) hit = 0;
                if (sel == PAT_ID && line_buf[i+j] != TXT_PID[j]) hit = 0;
            end
            if (hit)
                return 1;
        end
        return 0;
    endfunction

    task automatic pull_eui(int len);
        int comma;
        int n;
        logic [7:0] c;
        comma = len;
        n = 0;
        for (int i = 0; i < len; i++)
            if (line_buf[i] == CH_COMMA && comma == len)
                comma = i;
        if (comma == len) begin
            put(KIND_STATUS, 8'h00, ST_BAD_FMT);
            return;
        end
        for (int i = comma + 2; i < len && n < EUI_CAP; i++) begin
            c = line_buf[i];
            if (c != CH_COLON) begin
                if (c >= "A" && c <= "Z")
                    c = c + 8'd32;
                put(KIND_EUI, c, 2'd0);
                n++;
            end
        end
        if (n == 0)
            put(KIND_STATUS, 8'h00, ST_EMPTY_EUI);
    endtask

    task automatic end_of_line();
        int len;
        len = line_len;
        if (len > 0 && line_buf[len-1] == CH_CR)
            len--;
        for (int i = 0; i < len; i++)
            if (line_buf[i] == CH_NUL)
            begin
                len = i;
                break;
            end
        if (ph == PH_WAIT_AT && contains(len, PAT_OK)) begin
            foreach (TXT_VER[i]) put(KIND_TX, TXT_VER[i], 2'd0);
            ph = PH_WAIT_VER;
        end else if (ph == PH_WAIT_VER && contains(len, PAT_VER)) begin
            foreach (TXT_ID[i]) put(KIND_TX, TXT_ID[i], 2'd0);
            ph = PH_WAIT_ID;
        end else if (ph == PH_WAIT_ID && contains(len, PAT_ID)) begin
            pull_eui(len);
            ph = PH_IDLE;
        end
        timer = 0;
        line_len = 0;
    endtask

    task automatic predict_item(in_item_t it);
        item_res.delete();
        if (it.req_type == REQ_BUTTON) begin
            if (ph == PH_IDLE) begin
                tries = 0;
                send_attempt();
            end
        end else if (it.req_type == REQ_TICK) begin
            if (ph != PH_IDLE) begin
                if (timer != 16'hFFFF)
                    timer = timer + 16'd1;
                if (timer >= timeout_reg) begin
                    timer = 0;
                    line_len = 0;
                    if (ph == PH_WAIT_AT)
                        send_attempt();
                    else begin
                        put(KIND_STATUS, 8'h00, ST_STOPPED);
                        ph = PH_IDLE;
                    end
                end
            end
        end else if (it.req_type == REQ_BYTE) begin
            if (ph != PH_IDLE) begin
                if (it.rx_byte == CH_LF)
                    end_of_line();
                else if (line_len < LINE_DEPTH - 1) begin
                    line_buf[line_len] = it.rx_byte;
                    line_len++;
                end
            end
        end
        if (item_res.size() > 0)
            item_res[item_res.size()-1].last = 1'b1;
        foreach (item_res[i]) want_q.push_back(item_res[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t w;
        if (!rst_n)
        begin
            timeout_reg = TIMEOUT_RESET;
            retries_reg = RETRIES_RESET;
            ph = PH_IDLE;
            tries = 0;
            timer = 0;
            line_len = 0;
            want_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_TIMEOUT) timeout_reg = cfg_data;
                else if (cfg_index == CFG_RETRIES) retries_reg = cfg_data[3:0];
            end
            if (in_valid && !in_stall)
                predict_item(in_data);
            if (out_valid && !out_stall) begin
                if (want_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %p", out_data);
                end else begin
                    w = want_q.pop_front();
                    if (w !== out_data) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p got %p", w, out_data);
                    end
                end
            end
            pending = want_q.size();
        end
    end
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// testbench top for at_command_bringup_sequencer_core: clock, reset, stimulus, verdict
// depends on atbs_pkg, the core and atbs_checker
module tb;
    import atbs_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycles;
    bit          hold_off;
    bit          no_stall;

    at_command_bringup_sequencer_core dut (.*);

    atbs_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall pattern, long hold-off when asked, free runs at times
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (no_stall)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    initial
    begin
        no_stall = 0;
        forever
        begin
            repeat ($urandom_range(50, 300)) @(posedge clk);
            no_stall = !no_stall;
        end
    end

    int gap_left;
    int burst_left;
    int sent;

    // one transfer on the in channel, with bursts and gaps
    task automatic send(logic [1:0] r, logic [7:0] b);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap_left) @(negedge clk);
            end
        end
        burst_left--;
        sent++;
        in_valid <= 1'b1;
        in_data <= '{req_type: r, rx_byte: b};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send(REQ_BYTE, s[i]);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [15:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic rand_line();
        int n;
        int kind;
        kind = $urandom_range(0, 9);
        n = $urandom_range(0, 12);
        if (kind < 3)
            send_text("OK");
        else if (kind < 5)
            send_text("+VER 1.0");
        else if (kind < 7)
        begin
            send_text("+ID: DevEui, ");
            for (int i = 0; i < n + 8; i++)
                send(REQ_BYTE, ($urandom_range(0, 3) == 0) ? CH_COLON
                                                          : 8'($urandom_range(32, 255)));
        end
        else if (kind == 7)
        begin
            for (int i = 0; i < (($urandom_range(0, 6) == 0) ? 140 : n); i++)
                send(REQ_BYTE, 8'($urandom));
        end
        if ($urandom_range(0, 1))
            send(REQ_BYTE, CH_CR);
        send(REQ_BYTE, CH_LF);
    endtask

    initial
    begin
        int base;
        int r;
        hold_off = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TIMEOUT;
        cfg_data = '0;
        burst_left = 0;
        sent = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: stray items, then full happy path, mixed-case eui and colons
        send(REQ_TICK, 8'h00);
        send(REQ_BYTE, 8'hFF);
        send(2'd3, 8'h00);
        send(REQ_BUTTON, 8'h00);
        send(REQ_BUTTON, 8'h00);
        send_text("OK\r\n");
        send_text("+VER\n");
        send_text("+ID: DevEui, 2C:F7:F1:20:AB:cd:EF:01:99\r\n");
        // bad format and empty eui, then no-response and stopped timeouts
        send(REQ_BUTTON, 8'h00);
        send_text("OK\n+VER\n+ID: DevEui no comma\n");
        send(REQ_BUTTON, 8'h00);
        send_text("OK\n+VER\n+ID: DevEui,\n");
        write_reg(CFG_RETRIES, 16'd0);
        send(REQ_BUTTON, 8'h00);
        write_reg(CFG_TIMEOUT, 16'd1);
        write_reg(CFG_RETRIES, 16'd15);
        send(REQ_BUTTON, 8'h00);
        for (int i = 0; i < 16; i++)
            send(REQ_TICK, 8'h00);
        write_reg(CFG_TIMEOUT, 16'd3);
        write_reg(CFG_RETRIES, 16'd2);
        send(REQ_BUTTON, 8'h00);
        send_text("OK\n");
        repeat (3) send(REQ_TICK, 8'h00);
        write_reg(CFG_TIMEOUT, 16'hFFFF);

        // receiver holds off while items keep coming
        send(REQ_BUTTON, 8'h00);
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            begin
                send_text("OK\n+VER\n");
                send_text("+ID: DevEui, 0123456789ABCDEF0123\n");
            end
        join

        // random part in phases with different settings, about 420 items in all
        base = sent;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_TIMEOUT, (ph == 5) ? 16'd65535 : 16'($urandom_range(2, 30)));
            write_reg(CFG_RETRIES, 16'($urandom_range(0, 15)));
            while (sent < base + ((420 - base) * (ph + 1)) / 6)
            begin
                r = $urandom_range(0, 9);
                if (r < 2)
                    send(REQ_BUTTON, 8'($urandom));
                else if (r < 4)
                    send(REQ_TICK, 8'($urandom));
                else if (r == 4)
                    send(2'($urandom), 8'($urandom));
                else
                    rand_line();
            end
        end

        settle();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

>>> at_command_bringup_sequencer_core.f
design/atbs_pkg.sv
design/atbs_line_ram.sv
design/at_command_bringup_sequencer_core.sv
tb/sv/atbs_checker.sv
tb/sv/tb.sv
